// ===== rtl/pdc_pkg.sv =====
// Shared types, widths and register codes of the pixel difference counter.
package pdc_pkg;

    localparam int PIXEL_W    = 32;
    localparam int CFG_DIM_W  = 13;
    localparam int THRESH_W   = 17;
    localparam int REGION_W   = 64;
    localparam int FIELD_W    = 16;
    localparam int COUNT_W    = 25;
    localparam int PCT_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_W      = 40;   // changed * 25600 fits below 2^40
    localparam int PROD_W     = 42;   // threshold_q16 * total
    localparam int PCT_SCALE  = 25600; // 100 in Q8
    localparam int Q16_SHIFT  = 16;
    localparam int AA_LIMIT   = 3;
    localparam int BASE_LIMIT = 1;

    typedef logic [PIXEL_W-1:0]   pixel_t;
    typedef logic [REGION_W-1:0]  region_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [PCT_W-1:0]     pct_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [FIELD_W-1:0]   field_t;

    localparam cfg_idx_t REG_IMAGE_WIDTH  = 3'd0;
    localparam cfg_idx_t REG_IMAGE_HEIGHT = 3'd1;
    localparam cfg_idx_t REG_AA_TOLERANCE = 3'd2;
    localparam cfg_idx_t REG_THRESHOLD    = 3'd3;
    localparam cfg_idx_t REG_REGION_0     = 3'd4;

endpackage

// ===== rtl/pdc_if.sv =====
// Handshake channels of the pixel difference counter: pixel pairs, results, register writes.
interface pdc_pixel_if;
    import pdc_pkg::*;
    logic   valid;
    logic   ready;
    pixel_t baseline_pixel;
    pixel_t actual_pixel;
    modport source (output valid, baseline_pixel, actual_pixel, input ready);
    modport sink   (input valid, baseline_pixel, actual_pixel, output ready);
endinterface

interface pdc_result_if;
    import pdc_pkg::*;
    logic   valid;
    logic   ready;
    logic   matches_res;
    count_t changed_pixels;
    count_t total_pixels;
    pct_t   diff_percent_q8;
    modport source (output valid, matches_res, changed_pixels, total_pixels,
                    diff_percent_q8, input ready);
    modport sink   (input valid, matches_res, changed_pixels, total_pixels,
                    diff_percent_q8, output ready);
endinterface

interface pdc_cfg_if;
    import pdc_pkg::*;
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    region_t  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/pixel_diff_counter.sv =====
// Pixel difference counter: counts changed pixels of a frame and reports the changed fraction.
// Each pixel pair is accepted in ST_IDLE, then passes each ignore rectangle in turn
// through the shared rectangle test and updates the counters in ST_UPDATE; ready is low meanwhile.
// After the last pixel of a frame come the multiplies and the compare, then the 40-step divider
// forms the percentage, then the output register loads once the previous result is taken.
// Reset restores the register reset values, clears the counters and drops a waiting result.
module pixel_diff_counter #(
    parameter int CHANNEL_BYTES = 4,
    parameter int MAX_DIM       = 4096,
    parameter int REGIONS       = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    pdc_pixel_if.sink     pixel,
    pdc_result_if.source  result,
    pdc_cfg_if.sink       cfg
);
    import pdc_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int EDIM_W = DIM_W + 1;
    localparam int RIDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int DIST_W = 8 + $clog2(CHANNEL_BYTES + 1);

    // Sequencer states.
    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_CHECK   = 8'b0000_0010,
        ST_UPDATE  = 8'b0000_0100,
        ST_TOTAL   = 8'b0000_1000,
        ST_MATCH   = 8'b0001_0000,
        ST_COMPARE = 8'b0010_0000,
        ST_DIVIDE  = 8'b0100_0000,
        ST_EMIT    = 8'b1000_0000
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic                 aa_reg;
    logic [THRESH_W-1:0]  thresh_reg;
    region_t              region_reg [REGIONS];

    // Frame position and running count.
    logic [DIM_W-1:0]     column_reg;
    logic [DIM_W-1:0]     row_reg;
    count_t               changed_reg;

    // Per-pixel work registers.
    pixel_t               base_reg;
    pixel_t               act_reg;
    logic [RIDX_W-1:0]    region_idx_reg;
    logic                 hit_reg;

    // End-of-frame work registers.
    count_t               fin_changed_reg;
    count_t               total_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [PROD_W-1:0]    thr_prod_reg;
    logic                 match_reg;

    // Output register.
    logic                 res_valid_reg;
    logic                 res_match_reg;
    count_t               res_changed_reg;
    count_t               res_total_reg;
    pct_t                 res_pct_reg;

    logic [EDIM_W-1:0]    eff_w;
    logic [EDIM_W-1:0]    eff_h;
    logic                 region_hit;
    logic [DIST_W-1:0]    pix_dist;
    logic [DIST_W-1:0]    limit;
    logic [7:0]           byte_a;
    logic [7:0]           byte_b;
    logic [7:0]           byte_diff;
    logic                 pixel_changed;
    count_t               changed_inc;
    logic                 row_end;
    logic                 frame_end;
    logic                 div_start;
    logic                 div_done;
    logic [NUM_W-1:0]     div_quotient;
    logic                 pixel_accept;
    logic                 res_load;

    // Clamp the dimensions: zero acts as one, anything above MAX_DIM as MAX_DIM.
    always_comb
    begin
        if (width_reg == '0)
            eff_w = EDIM_W'(1);
        else if (width_reg > CFG_DIM_W'(MAX_DIM))
            eff_w = EDIM_W'(MAX_DIM);
        else
            eff_w = width_reg[EDIM_W-1:0];

        if (height_reg == '0)
            eff_h = EDIM_W'(1);
        else if (height_reg > CFG_DIM_W'(MAX_DIM))
            eff_h = EDIM_W'(MAX_DIM);
        else
            eff_h = height_reg[EDIM_W-1:0];
    end

    // One rectangle per cycle through the shared test.
    pdc_region_unit u_region (
        .region (region_reg[region_idx_reg]),
        .x      (FIELD_W'(column_reg)),
        .y      (FIELD_W'(row_reg)),
        .hit    (region_hit)
    );

    // Sum of absolute byte differences over the active channels.
    always_comb
    begin
        pix_dist  = '0;
        byte_a    = '0;
        byte_b    = '0;
        byte_diff = '0;
        for (int c = 0; c < CHANNEL_BYTES; c++)
        begin
            byte_a    = base_reg[8*c +: 8];
            byte_b    = act_reg[8*c +: 8];
            byte_diff = (byte_a > byte_b) ? (byte_a - byte_b) : (byte_b - byte_a);
            pix_dist  = pix_dist + DIST_W'(byte_diff);
        end
    end

    assign limit         = aa_reg ? DIST_W'(AA_LIMIT) : DIST_W'(BASE_LIMIT);
    assign pixel_changed = !hit_reg && (pix_dist > limit);
    assign changed_inc   = changed_reg + COUNT_W'(pixel_changed);

    // Compare with >= so that a shrunk dimension still ends the row or frame.
    assign row_end   = {1'b0, column_reg} >= (eff_w - EDIM_W'(1));
    assign frame_end = row_end && ({1'b0, row_reg} >= (eff_h - EDIM_W'(1)));

    assign pixel.ready  = (state_reg == ST_IDLE);
    assign pixel_accept = pixel.valid && pixel.ready;
    assign cfg.ready    = 1'b1;
    assign div_start    = (state_reg == ST_COMPARE);
    assign res_load     = (state_reg == ST_EMIT) && (!res_valid_reg || result.ready);

    pdc_divider #(
        .NUM_W (NUM_W),
        .DEN_W (COUNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (num_reg),
        .denom    (total_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Control state, configuration and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            width_reg      <= CFG_DIM_W'(1);
            height_reg     <= CFG_DIM_W'(1);
            aa_reg         <= 1'b0;
            thresh_reg     <= '0;
            for (int i = 0; i < REGIONS; i++)
            begin
                region_reg[i] <= '0;
            end
            column_reg     <= '0;
            row_reg        <= '0;
            changed_reg    <= '0;
            region_idx_reg <= '0;
            hit_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            // Register writes; unknown indexes drop.
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_IMAGE_WIDTH)
                    width_reg <= cfg.data[CFG_DIM_W-1:0];
                if (cfg.index == REG_IMAGE_HEIGHT)
                    height_reg <= cfg.data[CFG_DIM_W-1:0];
                if (cfg.index == REG_AA_TOLERANCE)
                    aa_reg <= cfg.data[0];
                if (cfg.index == REG_THRESHOLD)
                    thresh_reg <= cfg.data[THRESH_W-1:0];
                for (int i = 0; i < REGIONS; i++)
                begin
                    if (cfg.index == CFG_IDX_W'(int'(REG_REGION_0) + i))
                        region_reg[i] <= cfg.data;
                end
            end

            // Drop the result once it is taken; a new load wins.
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (pixel_accept)
                    begin
                        region_idx_reg <= '0;
                        hit_reg        <= 1'b0;
                        state_reg      <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    hit_reg <= hit_reg || region_hit;
                    if (region_idx_reg == RIDX_W'(REGIONS - 1))
                        state_reg <= ST_UPDATE;
                    else
                        region_idx_reg <= region_idx_reg + RIDX_W'(1);
                end
                ST_UPDATE:
                begin
                    if (frame_end)
                    begin
                        column_reg  <= '0;
                        row_reg     <= '0;
                        changed_reg <= '0;
                        state_reg   <= ST_TOTAL;
                    end
                    else if (row_end)
                    begin
                        column_reg  <= '0;
                        row_reg     <= row_reg + DIM_W'(1);
                        changed_reg <= changed_inc;
                        state_reg   <= ST_IDLE;
                    end
                    else
                    begin
                        column_reg  <= column_reg + DIM_W'(1);
                        changed_reg <= changed_inc;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_TOTAL:
                begin
                    state_reg <= ST_MATCH;
                end
                ST_MATCH:
                begin
                    state_reg <= ST_COMPARE;
                end
                ST_COMPARE:
                begin
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    if (div_done)
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (res_load)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            base_reg <= pixel.baseline_pixel;
            act_reg  <= pixel.actual_pixel;
        end
        if ((state_reg == ST_UPDATE) && frame_end)
            fin_changed_reg <= changed_inc;
        if (state_reg == ST_TOTAL)
        begin
            // Product of two clamped dimensions stays within 2^24.
            total_reg <= COUNT_W'(eff_w) * COUNT_W'(eff_h);
            num_reg   <= NUM_W'(fin_changed_reg) * NUM_W'(PCT_SCALE);
        end
        if (state_reg == ST_MATCH)
            thr_prod_reg <= PROD_W'(thresh_reg) * PROD_W'(total_reg);
        if (state_reg == ST_COMPARE)
            match_reg <= (PROD_W'(fin_changed_reg) << Q16_SHIFT) <= thr_prod_reg;
        if (res_load)
        begin
            res_match_reg   <= match_reg;
            res_changed_reg <= fin_changed_reg;
            res_total_reg   <= total_reg;
            res_pct_reg     <= div_quotient[PCT_W-1:0];
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.matches_res     = res_match_reg;
    assign result.changed_pixels  = res_changed_reg;
    assign result.total_pixels    = res_total_reg;
    assign result.diff_percent_q8 = res_pct_reg;

endmodule

// ===== rtl/pdc_region_unit.sv =====
// Shared rectangle test: is a pixel position inside one ignore rectangle.
module pdc_region_unit (
    input  pdc_pkg::region_t region,
    input  pdc_pkg::field_t  x,
    input  pdc_pkg::field_t  y,
    output logic             hit
);
    import pdc_pkg::*;

    field_t             rx;
    field_t             ry;
    field_t             rw;
    field_t             rh;
    logic [FIELD_W:0]   x_end;
    logic [FIELD_W:0]   y_end;

    assign rx    = region[FIELD_W-1:0];
    assign ry    = region[2*FIELD_W-1:FIELD_W];
    assign rw    = region[3*FIELD_W-1:2*FIELD_W];
    assign rh    = region[4*FIELD_W-1:3*FIELD_W];
    assign x_end = {1'b0, rx} + {1'b0, rw};
    assign y_end = {1'b0, ry} + {1'b0, rh};

    // A zero width disables the rectangle.
    assign hit = (rw != '0) && (x >= rx) && ({1'b0, x} < x_end)
              && (y >= ry) && ({1'b0, y} < y_end);

endmodule

// ===== rtl/pdc_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module pdc_divider #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 25
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= denom;
            quo_reg <= numer;
        end
        else if (busy_reg)
        begin
            // Shift the next dividend bit in, subtract when it fits.
            rem_reg <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
